// File: src/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Clocked check that also runs during reset.
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

// File: src/qcn_pkg.sv
package qcn_pkg;

    // Width of every quaternion component on the ports and in the state.
    localparam int DATA_W = 16;

    // Width of one exact sum of four 16x16 products.
    localparam int PSUM_W = 34;

    // Component indexes, in w, x, y, z order.
    localparam logic [1:0] C_W = 2'd0;
    localparam logic [1:0] C_X = 2'd1;
    localparam logic [1:0] C_Y = 2'd2;
    localparam logic [1:0] C_Z = 2'd3;

    // Input word: the right-hand quaternion.
    typedef struct packed {
        logic signed [DATA_W-1:0] in_w;
        logic signed [DATA_W-1:0] in_x;
        logic signed [DATA_W-1:0] in_y;
        logic signed [DATA_W-1:0] in_z;
    } qcn_in_t;

    // Result word: the normalized new orientation.
    typedef struct packed {
        logic signed [DATA_W-1:0] out_w;
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     zero_magnitude;
    } qcn_out_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_ROUND,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV_START,
        ST_DIV,
        ST_DONE
    } qcn_state_t;

    // Sign of Hamilton product term t of component c. Term t always uses the
    // left-hand component t and the right-hand component c xor t.
    function automatic logic term_neg(input logic [1:0] c, input logic [1:0] t);
        logic neg;
        case (c)
            C_W: neg = (t != C_W);
            C_X: neg = (t == C_Z);
            C_Y: neg = (t == C_X);
            C_Z: neg = (t == C_Y);
            default: neg = 1'b0;
        endcase
        return neg;
    endfunction

endpackage

// File: src/quaternion_compose_normalize_top.sv
// Per accepted word, one multiplier serves the 16 product terms and 4 squares, then a
// one-root-bit-per-cycle square root and four one-bit-per-cycle divisions run in turn;
// a product of zero length skips the divisions. The block takes a new word only when
// idle, once the last result has been loaded into the output register.
// Reset (aresetn low, synchronous): orientation returns to identity, no result pending.
module quaternion_compose_normalize_top #(
    parameter int FRAC_BITS = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  qcn_pkg::qcn_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output qcn_pkg::qcn_out_t m_data
);

    import qcn_pkg::*;

    // Magnitude width of a rounded product component, multiplier operand
    // width, sum of squares width and root width.
    localparam int QMW = PSUM_W - FRAC_BITS;
    localparam int MW  = (QMW + 1 > 17) ? QMW + 1 : 17;
    localparam int SQW = 2 * QMW + 2;
    localparam int RTW = QMW + 1;

    // Saturation limits of the output, as magnitudes.
    localparam logic [32:0] SAT_POS = (FRAC_BITS < 15) ? (33'd1 << FRAC_BITS) : 33'd32767;
    localparam logic [32:0] SAT_NEG = (FRAC_BITS < 15) ? (33'd1 << FRAC_BITS) : 33'd32768;
    localparam logic [PSUM_W-1:0] HALF = PSUM_W'(1) << (FRAC_BITS - 1);

    qcn_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    logic issue;
    logic sqrt_start;
    logic div_start;
    logic out_load;

    logic signed [DATA_W-1:0] orient_reg [4];
    logic signed [DATA_W-1:0] in_hold_reg [4];
    logic signed [PSUM_W-1:0] psum_reg [4];
    logic [QMW-1:0]           qmag_reg [4];
    logic [3:0]               qneg_reg;
    logic signed [PSUM_W-1:0] acc_reg;
    logic [SQW-1:0]           sq_acc_reg;
    logic                     zero_reg;

    logic       mul_vld_reg;
    logic [3:0] mul_tag_reg;
    logic       mul_neg_reg;

    logic                   m_valid_reg;
    qcn_out_t               m_data_reg;

    logic signed [MW-1:0]   op_a;
    logic signed [MW-1:0]   op_b;
    logic signed [2*MW-1:0] mul_prod;
    logic [QMW-1:0]         qmag_sel;
    logic [1:0]             term_c;
    logic [1:0]             term_t;

    logic signed [PSUM_W-1:0] prod_lo;
    logic signed [PSUM_W-1:0] acc_sum;
    logic [SQW-1:0]           sq_sum;
    logic [QMW-1:0]           rnd_mag [4];
    logic [3:0]               rnd_neg;

    logic                   sqrt_done;
    logic [RTW-1:0]         sqrt_root;
    logic                   div_done;
    logic [FRAC_BITS:0]     div_quot;
    logic [32:0]            quot_ext;
    logic [32:0]            pos_val;
    logic [32:0]            neg_mag;
    logic [32:0]            sat_val;

    // Shared multiplier and divider, and the square root unit.
    qcn_mult #(.MW(MW)) u_mult (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (mul_prod)
    );

    qcn_isqrt #(.RTW(RTW)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_sum),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    qcn_divider #(.FRAC_BITS(FRAC_BITS), .QMW(QMW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (qmag_sel),
        .root    (sqrt_root),
        .done    (div_done),
        .quot    (div_quot)
    );

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Sequencer: next state and unit strobes.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        issue      = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_PROD;
                    cnt_next   = '0;
                end
            end
            ST_PROD: begin
                if (!cnt_reg[4]) begin
                    issue    = 1'b1;
                    cnt_next = cnt_reg + 5'd1;
                end
                if (mul_vld_reg && (&mul_tag_reg)) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                state_next = ST_SQUARE;
                cnt_next   = '0;
            end
            ST_SQUARE: begin
                if (!cnt_reg[2]) begin
                    issue    = 1'b1;
                    cnt_next = cnt_reg + 5'd1;
                end
                if (mul_vld_reg && (&mul_tag_reg[1:0])) begin
                    sqrt_start = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    cnt_next   = '0;
                    state_next = (sqrt_root == '0) ? ST_DONE : ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (&cnt_reg[1:0]) begin
                        state_next = ST_DONE;
                    end else begin
                        cnt_next   = cnt_reg + 5'd1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Multiplier operands: product terms, or the squares of the magnitudes.
    always_comb begin
        term_c   = cnt_reg[3:2];
        term_t   = cnt_reg[1:0];
        qmag_sel = qmag_reg[cnt_reg[1:0]];
        if (state_reg == ST_SQUARE) begin
            op_a = {{(MW-QMW){1'b0}}, qmag_sel};
            op_b = {{(MW-QMW){1'b0}}, qmag_sel};
        end else begin
            op_a = {{(MW-DATA_W){orient_reg[term_t][DATA_W-1]}}, orient_reg[term_t]};
            op_b = {{(MW-DATA_W){in_hold_reg[term_c ^ term_t][DATA_W-1]}},
                    in_hold_reg[term_c ^ term_t]};
        end
    end

    // Accumulator inputs and the rounding of the four product sums.
    always_comb begin
        prod_lo = mul_prod[PSUM_W-1:0];
        acc_sum = acc_reg + (mul_neg_reg ? -prod_lo : prod_lo);
        sq_sum  = sq_acc_reg + {2'b00, mul_prod[2*QMW-1:0]};
        for (int c = 0; c < 4; c++) begin
            logic [PSUM_W-1:0] pmag;
            logic [PSUM_W-1:0] rsum;
            pmag       = psum_reg[c][PSUM_W-1] ? PSUM_W'(-psum_reg[c]) : PSUM_W'(psum_reg[c]);
            rsum       = pmag + HALF;
            rnd_mag[c] = rsum[PSUM_W-1:FRAC_BITS];
            rnd_neg[c] = psum_reg[c][PSUM_W-1];
        end
    end

    // Signed, saturated quotient of the component now being divided.
    always_comb begin
        quot_ext = {{(32-FRAC_BITS){1'b0}}, div_quot};
        pos_val  = (quot_ext > SAT_POS) ? SAT_POS : quot_ext;
        neg_mag  = (quot_ext > SAT_NEG) ? SAT_NEG : quot_ext;
        sat_val  = qneg_reg[cnt_reg[1:0]] ? -neg_mag : pos_val;
    end

    // Multiplier tags follow the product through its register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
        end else begin
            mul_vld_reg <= issue;
        end
        mul_tag_reg <= cnt_reg[3:0];
        mul_neg_reg <= term_neg(term_c, term_t);
    end

    // Input hold, product sums, squares and rounding.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_hold_reg[0] <= s_data.in_w;
            in_hold_reg[1] <= s_data.in_x;
            in_hold_reg[2] <= s_data.in_y;
            in_hold_reg[3] <= s_data.in_z;
            acc_reg        <= '0;
        end
        if (state_reg == ST_PROD && mul_vld_reg) begin
            if (&mul_tag_reg[1:0]) begin
                psum_reg[mul_tag_reg[3:2]] <= acc_sum;
                acc_reg                    <= '0;
            end else begin
                acc_reg <= acc_sum;
            end
        end
        if (state_reg == ST_ROUND) begin
            for (int c = 0; c < 4; c++) begin
                qmag_reg[c] <= rnd_mag[c];
            end
            qneg_reg   <= rnd_neg;
            sq_acc_reg <= '0;
        end
        if (state_reg == ST_SQUARE && mul_vld_reg) begin
            sq_acc_reg <= sq_sum;
        end
        if (state_reg == ST_SQRT && sqrt_done) begin
            zero_reg <= (sqrt_root == '0);
        end
    end

    // Orientation state: identity after reset, cleared on zero length.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_reg[0] <= SAT_POS[DATA_W-1:0];
            orient_reg[1] <= '0;
            orient_reg[2] <= '0;
            orient_reg[3] <= '0;
        end else if (state_reg == ST_SQRT && sqrt_done && sqrt_root == '0) begin
            for (int c = 0; c < 4; c++) begin
                orient_reg[c] <= '0;
            end
        end else if (state_reg == ST_DIV && div_done) begin
            orient_reg[cnt_reg[1:0]] <= sat_val[DATA_W-1:0];
        end
    end

    // Output register: the next word may be accepted while this one waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.out_w          <= orient_reg[0];
            m_data_reg.out_x          <= orient_reg[1];
            m_data_reg.out_y          <= orient_reg[2];
            m_data_reg.out_z          <= orient_reg[3];
            m_data_reg.zero_magnitude <= zero_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: src/qcn_mult.sv
module qcn_mult #(
    parameter int MW = 17
) (
    input  logic                   aclk,
    input  logic signed [MW-1:0]   op_a,
    input  logic signed [MW-1:0]   op_b,
    output logic signed [2*MW-1:0] prod
);

    logic signed [2*MW-1:0] prod_reg;

    // Registered signed multiplier.
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// File: src/qcn_isqrt.sv
module qcn_isqrt #(
    parameter int RTW = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [2*RTW-1:0] radicand,
    output logic             done,
    output logic [RTW-1:0]   root
);

    localparam int CW = $clog2(RTW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [2*RTW-1:0] rad_reg;
    logic [RTW+1:0]   rem_reg;
    logic [RTW-1:0]   root_reg;

    logic [RTW+3:0]   cur;
    logic [RTW+3:0]   trial;
    logic [RTW+3:0]   diff;
    logic             ge;

    // One result bit per step: bring down two radicand bits and try root*4+1.
    always_comb begin
        cur   = {rem_reg, rad_reg[2*RTW-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        diff  = cur - trial;
        ge    = (cur >= trial);
    end

    // Control: busy for RTW steps, then a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RTW - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    // Datapath: radicand shift register, partial remainder and root.
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= rad_reg << 2;
            if (ge) begin
                rem_reg  <= diff[RTW+1:0];
                root_reg <= {root_reg[RTW-2:0], 1'b1};
            end else begin
                rem_reg  <= cur[RTW+1:0];
                root_reg <= {root_reg[RTW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: src/qcn_divider.sv
module qcn_divider #(
    parameter int FRAC_BITS = 14,
    parameter int QMW       = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [QMW-1:0]     mag,
    input  logic [QMW:0]       root,
    output logic               done,
    output logic [FRAC_BITS:0] quot
);

    // Quotient bits, numerator width and divisor width.
    localparam int QTW = FRAC_BITS + 1;
    localparam int NW  = QMW + QTW + 1;
    localparam int DW  = QMW + 2;
    localparam int CW  = $clog2(QTW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [QTW-1:0] low_reg;

    logic [NW-1:0] numer;
    logic [DW:0]   cur;
    logic [DW:0]   diff;
    logic          ge;

    // Rounded quotient: (2*mag*2^F + m) / (2*m). The quotient never exceeds
    // 2^F, so the upper numerator bits preload the remainder.
    always_comb begin
        numer = {1'b0, mag, {QTW{1'b0}}} + {{(NW-QMW-1){1'b0}}, root};
        cur   = {rem_reg, low_reg[QTW-1]};
        diff  = cur - {1'b0, dvs_reg};
        ge    = (cur >= {1'b0, dvs_reg});
    end

    // Control: QTW restoring steps, then a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QTW - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    // Datapath: the low numerator bits shift out as quotient bits shift in.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, numer[NW-1:QTW]};
            low_reg <= numer[QTW-1:0];
            dvs_reg <= {root, 1'b0};
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DW-1:0] : cur[DW-1:0];
            low_reg <= {low_reg[QTW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

// File: src/qcn_checker.sv
`include "assert_macros.svh"

module qcn_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input qcn_pkg::qcn_out_t m_data
);

    import qcn_pkg::*;

    logic out_cleared;

    // All four components of the result word are zero.
    assign out_cleared = (m_data.out_w == '0) && (m_data.out_x == '0) &&
                         (m_data.out_y == '0) && (m_data.out_z == '0);

    // A waiting result word holds until it is taken.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // The block works on one word at a time.
    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready)

    // A zero-length product clears every component of the result.
    `ASSERT_CLK(a_zero_clears, aclk, aresetn, m_valid && m_data.zero_magnitude |-> out_cleared)

    // Reset leaves the block ready with no result pending.
    `ASSERT_CLK_NR(a_reset_idle, aclk, !aresetn |=> !m_valid && s_ready)

endmodule

bind quaternion_compose_normalize_top qcn_checker u_qcn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
